/* hdl/tpt_pkg.sv */
// Shared types, constants and fixed-point helpers for the thermopile temperature block.
package tpt_pkg;

  localparam int PIXEL_COUNT_DEF = 64;
  localparam int FRAC = 24;
  localparam int RAWQ_W = 17 + FRAC;

  localparam int MUL_W = 64;
  localparam int DIV_NW = 80;
  localparam int DIV_DW = 49;
  localparam int SQ_IW = 100;
  localparam int SQ_RW = SQ_IW / 2;
  localparam int K4_W = 56;
  localparam int K4_SHIFT = 2 * FRAC - 8;

  typedef logic signed [127:0] wide_t;

  localparam wide_t W48_MAX = (128'sd1 <<< 47) - 128'sd1;
  localparam wide_t W48_MIN = -(128'sd1 <<< 47);
  localparam wide_t W20_MAX = 128'sd524287;
  localparam wide_t W20_MIN = -128'sd524288;

  localparam logic signed [47:0] ONE_Q = 48'sd1 <<< FRAC;
  localparam logic signed [47:0] TWENTYFIVE_Q = 48'sd25 <<< FRAC;
  localparam logic signed [63:0] KELVIN_OFS =
    (64'sd27315 * (64'sd1 <<< FRAC) + 64'sd50) / 64'sd100;
  localparam wide_t KELVIN_Q8 = (128'sd27315 * 128'sd256 + 128'sd50) / 128'sd100;
  localparam logic [K4_W-1:0] K4_MAX = '1;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [SQ_IW-1:0] arg;
  } sq_req_t;

  function automatic logic signed [47:0] sat48(input wide_t v);
    if (v > W48_MAX) return W48_MAX[47:0];
    else if (v < W48_MIN) return W48_MIN[47:0];
    else return v[47:0];
  endfunction

  function automatic logic signed [19:0] sat20(input wide_t v);
    if (v > W20_MAX) return W20_MAX[19:0];
    else if (v < W20_MIN) return W20_MIN[19:0];
    else return v[19:0];
  endfunction

  // Product of two Q.F values back to Q.F: floor, then clamp.
  function automatic logic signed [47:0] mulq(input wide_t p);
    return sat48(p >>> FRAC);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? n : v;
  endfunction

endpackage

/* hdl/tpt_mul.sv */
// Sequential 64 x 64 magnitude multiplier, one 64 x 16 partial product per cycle.
module tpt_mul
  import tpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output logic     done,
  output wide_t    prod
);

  logic [MUL_W-1:0] a;
  logic [MUL_W-1:0] b;
  logic             neg;
  logic [127:0]     acc;
  logic [1:0]       cnt;
  logic             busy;
  logic [79:0]      pp;

  assign pp = a * b[15:0];
  assign prod = neg ? wide_t'(-acc) : wide_t'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a <= req.a;
        b <= req.b;
        neg <= req.neg;
        acc <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + ({48'b0, pp} << {cnt, 4'b0});
        b <= b >> 16;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/tpt_div.sv */
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module tpt_div
  import tpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output logic     done,
  output wide_t    quot
);

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] q;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic              neg;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign rem_sh = {rem, q[DIV_NW-1]};
  assign diff = rem_sh - {1'b0, den};
  assign ge = !diff[DIV_DW];
  assign quot = neg ? -wide_t'(q) : wide_t'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        q <= req.num;
        den <= req.den;
        neg <= req.neg;
        rem <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        q <= {q[DIV_NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/tpt_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle, floored.
module tpt_sqrt
  import tpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  sq_req_t          req,
  output logic             done,
  output logic [SQ_RW-1:0] root
);

  localparam int CW = $clog2(SQ_RW);
  localparam int RW = SQ_RW + 2;

  logic [SQ_IW-1:0] arg;
  logic [RW-1:0]    rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [RW+1:0]    r_sh;
  logic [RW+1:0]    trial;
  logic [RW+2:0]    diff;
  logic             ge;

  assign r_sh = {rem, arg[SQ_IW-1 -: 2]};
  assign trial = {2'b0, root, 2'b01};
  assign diff = {1'b0, r_sh} - {1'b0, trial};
  assign ge = !diff[RW+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        arg <= req.arg;
        rem <= '0;
        root <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[RW-1:0] : r_sh[RW-1:0];
        root <= {root[SQ_RW-2:0], ge};
        arg <= arg << 2;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(SQ_RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/thermopile_pixel_temperature.sv */
// Top level of the thermopile-array temperature compensation block.
//
// This block turns raw thermopile-array readings into temperatures in signed
// Q8 degrees C. A load item stores one pixel's offset, slope and sensitivity
// coefficients in an on-chip coefficient memory (the entry past the last pixel
// holds the compensation pixel's offset and slope). A ptat item solves the
// quadratic ambient equation, stores the ambient temperature and its kelvin
// fourth power, and returns the ambient temperature. A compensation-pixel item
// only updates the stored compensated value. An IR pixel item returns the
// object temperature after offset, gradient, emissivity and sensitivity
// compensation, through two nested square roots. A zero divisor or a negative
// root argument returns temperature 0 with range_error set. Multiplication,
// division and square root run on three sequential units under one sequencer:
// a 64 x 64 multiplier built from 64 x 16 partial products, an 80-bit
// restoring divider at one quotient bit per cycle, and a square-root unit at
// one root bit per cycle. The block handles one item at a time and holds
// in_stall high while it works. A load item is taken without leaving the idle
// state. An IR pixel item runs two 80-step divisions and two 50-step square
// roots. After reset the block computes the kelvin fourth power of the 25 C
// ambient default before it accepts its first item; configuration writes are
// taken at any time. A finished item waits in the output register while the
// next item is accepted and worked on.
module thermopile_pixel_temperature
  import tpt_pkg::*;
#(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [6:0]         pixel_index,
  input  logic signed [16:0] raw_sample,
  input  logic signed [47:0] coef_offset,
  input  logic signed [47:0] coef_slope,
  input  logic signed [47:0] coef_sensitivity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] temperature,
  output logic               result_kind,
  output logic [5:0]         result_pixel,
  output logic               range_error,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int DEPTH = PIXEL_COUNT + 1;
  localparam int AW = $clog2(DEPTH);
  localparam logic [25:0] EMIS_ONE = 26'd1 << 24;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PTAT  = 2'd1,
    FUNC_COMP  = 2'd2,
    FUNC_PIXEL = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_PTAT_OFFSET = 3'd0,
    REG_PTAT_LINEAR = 3'd1,
    REG_PTAT_SQUARE = 3'd2,
    REG_GRADIENT    = 3'd3,
    REG_EMISSIVITY  = 3'd4,
    REG_SENS_DRIFT  = 3'd5,
    REG_COMP_SENS   = 3'd6
  } cfg_reg_e;

  typedef enum logic [4:0] {
    IDLE, PT_M1W, PT_M2W, PT_SQW, PT_DVW,
    K4_START, K4_M1W, K4_M2W, K4_DONE,
    PX_RD, PX_M1W, PX_M2W, PX_DV1W, PX_M3W, PX_M4W, PX_M5W,
    PX_DV2W, PX_SQ1W, PX_SQ2W, EMIT
  } state_e;

  typedef struct packed {
    logic signed [47:0] sens;
    logic signed [47:0] slope;
    logic signed [47:0] ofs;
  } coef_t;

  // Configuration registers.
  logic signed [47:0] vth, k1, k2, tgc, ksta, acp;
  logic [25:0]        emis;

  // Persistent state.
  logic signed [47:0] ambient_temp;
  logic [K4_W-1:0]    k4;
  logic signed [47:0] comp_val;
  logic               k4_init;

  // Per-item working registers.
  state_e                    state;
  logic [1:0]                func_r;
  logic [6:0]                idx_r;
  logic signed [RAWQ_W-1:0]  raw_q;
  wide_t                     p1;
  logic signed [47:0]        off_v, vc, a1;
  logic signed [19:0]        res_temp;
  logic                      res_kind, res_err;
  logic [5:0]                res_pix;

  // Coefficient memory.
  coef_t   mem [DEPTH];
  coef_t   mem_q;
  logic    mem_rd, mem_wr;
  logic [AW-1:0] rd_addr;
  logic    idx_le, idx_lt;

  // Shared units.
  mul_req_t         mul_req;
  div_req_t         div_req;
  sq_req_t          sq_req;
  logic             mul_done, div_done, sq_done;
  wide_t            mul_p, div_q;
  logic [SQ_RW-1:0] sq_root;

  // Datapath around the units.
  logic signed [47:0] dt, mq, amb_new, off_new, tg_new, a1_new, a2_new;
  logic signed [63:0] d_ptat;
  wide_t              disc, num, x;
  logic [63:0]        k4_m, num_mag, tg_mag;
  logic signed [19:0] temp_obj, temp_amb;

  tpt_mul u_mul (.clk, .rst, .req(mul_req), .done(mul_done), .prod(mul_p));
  tpt_div u_div (.clk, .rst, .req(div_req), .done(div_done), .quot(div_q));
  tpt_sqrt u_sqrt (.clk, .rst, .req(sq_req), .done(sq_done), .root(sq_root));

  assign in_stall = (state != IDLE);

  always_comb begin
    idx_le = ({25'b0, pixel_index} <= 32'(PIXEL_COUNT));
    idx_lt = ({25'b0, pixel_index} < 32'(PIXEL_COUNT));
    mem_wr = (state == IDLE) && in_valid && (func_e'(func) == FUNC_LOAD) && idx_le;
    mem_rd = (state == IDLE) && in_valid &&
             ((func_e'(func) == FUNC_COMP) || ((func_e'(func) == FUNC_PIXEL) && idx_lt));
    rd_addr = (func_e'(func) == FUNC_COMP) ? AW'(PIXEL_COUNT) : AW'(pixel_index);
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[AW'(pixel_index)] <= '{sens: coef_sensitivity, slope: coef_slope, ofs: coef_offset};
    end
    if (mem_rd) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_comb begin
    dt = sat48(wide_t'(ambient_temp) - wide_t'(TWENTYFIVE_Q));
    mq = mulq(mul_p);
    d_ptat = 64'(vth) - 64'(raw_q);
    disc = p1 - (mul_p <<< 2);
    num = wide_t'($signed({1'b0, sq_root})) - wide_t'(k1);
    num_mag = mag64(num[63:0]);
    amb_new = sat48(div_q + wide_t'(TWENTYFIVE_Q));
    k4_m = mag64(64'(ambient_temp) + KELVIN_OFS);
    off_new = sat48(wide_t'(raw_q) - (wide_t'(mem_q.ofs) + wide_t'(mq)));
    tg_new = sat48(wide_t'(off_v) - wide_t'(mq));
    tg_mag = mag64(64'(tg_new));
    a1_new = sat48(wide_t'(ONE_Q) + wide_t'(mq));
    a2_new = sat48(wide_t'(mem_q.sens) - wide_t'(mq));
    x = div_q + wide_t'(k4);
    temp_obj = sat20(wide_t'($signed({1'b0, sq_root})) - KELVIN_Q8);
    temp_amb = sat20(wide_t'(ambient_temp) >>> (FRAC - 8));
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vth <= '0;
      k1 <= '0;
      k2 <= '0;
      tgc <= '0;
      emis <= EMIS_ONE;
      ksta <= '0;
      acp <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_PTAT_OFFSET: vth <= cfg_data;
        REG_PTAT_LINEAR: k1 <= cfg_data;
        REG_PTAT_SQUARE: k2 <= cfg_data;
        REG_GRADIENT:    tgc <= cfg_data;
        REG_EMISSIVITY:  emis <= cfg_data[25:0];
        REG_SENS_DRIFT:  ksta <= cfg_data;
        REG_COMP_SENS:   acp <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer. Each unit request is a one-cycle start with registered operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= K4_START;
      k4_init <= 1'b1;
      ambient_temp <= TWENTYFIVE_Q;
      comp_val <= '0;
      out_valid <= 1'b0;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      sq_req.start <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      sq_req.start <= 1'b0;
      // The EMIT state owns out_valid whenever it is active.
      if (out_valid && !out_stall && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            func_r <= func;
            idx_r <= pixel_index;
            raw_q <= {raw_sample, FRAC'(0)};
            unique case (func_e'(func))
              FUNC_LOAD: ;
              FUNC_PTAT: begin
                if (k2 == '0) begin
                  res_temp <= '0;
                  res_kind <= 1'b0;
                  res_pix <= '0;
                  res_err <= 1'b1;
                  state <= EMIT;
                end else begin
                  mul_req <= '{start: 1'b1, neg: 1'b0,
                               a: mag64(64'(k1)), b: mag64(64'(k1))};
                  state <= PT_M1W;
                end
              end
              FUNC_COMP: state <= PX_RD;
              FUNC_PIXEL: begin
                if (idx_lt) state <= PX_RD;
              end
            endcase
          end
        end

        PT_M1W: begin
          if (mul_done) begin
            p1 <= mul_p;
            mul_req <= '{start: 1'b1, neg: k2[47] ^ d_ptat[63],
                         a: mag64(64'(k2)), b: mag64(d_ptat)};
            state <= PT_M2W;
          end
        end

        PT_M2W: begin
          if (mul_done) begin
            if (disc[127]) begin
              res_temp <= '0;
              res_kind <= 1'b0;
              res_pix <= '0;
              res_err <= 1'b1;
              state <= EMIT;
            end else begin
              sq_req <= '{start: 1'b1, arg: disc[SQ_IW-1:0]};
              state <= PT_SQW;
            end
          end
        end

        PT_SQW: begin
          if (sq_done) begin
            div_req <= '{start: 1'b1, neg: num[127] ^ k2[47],
                         num: DIV_NW'({num_mag, FRAC'(0)}),
                         den: DIV_DW'({mag64(64'(k2)), 1'b0})};
            state <= PT_DVW;
          end
        end

        PT_DVW: begin
          if (div_done) begin
            ambient_temp <= amb_new;
            state <= K4_START;
          end
        end

        K4_START: begin
          mul_req <= '{start: 1'b1, neg: 1'b0, a: k4_m, b: k4_m};
          state <= K4_M1W;
        end

        K4_M1W: begin
          if (mul_done) begin
            if (mul_p[127:64+FRAC] != '0) begin
              k4 <= K4_MAX;
              state <= K4_DONE;
            end else begin
              mul_req <= '{start: 1'b1, neg: 1'b0,
                           a: mul_p[FRAC +: 64], b: mul_p[FRAC +: 64]};
              state <= K4_M2W;
            end
          end
        end

        K4_M2W: begin
          if (mul_done) begin
            k4 <= (mul_p[127:K4_SHIFT+K4_W] != '0) ? K4_MAX : mul_p[K4_SHIFT +: K4_W];
            state <= K4_DONE;
          end
        end

        K4_DONE: begin
          if (k4_init) begin
            k4_init <= 1'b0;
            state <= IDLE;
          end else begin
            res_temp <= temp_amb;
            res_kind <= 1'b0;
            res_pix <= '0;
            res_err <= 1'b0;
            state <= EMIT;
          end
        end

        PX_RD: begin
          mul_req <= '{start: 1'b1, neg: mem_q.slope[47] ^ dt[47],
                       a: mag64(64'(mem_q.slope)), b: mag64(64'(dt))};
          state <= PX_M1W;
        end

        PX_M1W: begin
          if (mul_done) begin
            if (func_e'(func_r) == FUNC_COMP) begin
              comp_val <= off_new;
              state <= IDLE;
            end else begin
              off_v <= off_new;
              mul_req <= '{start: 1'b1, neg: tgc[47] ^ comp_val[47],
                           a: mag64(64'(tgc)), b: mag64(64'(comp_val))};
              state <= PX_M2W;
            end
          end
        end

        PX_M2W: begin
          if (mul_done) begin
            if (emis == '0) begin
              res_temp <= '0;
              res_kind <= 1'b1;
              res_pix <= idx_r[5:0];
              res_err <= 1'b1;
              state <= EMIT;
            end else begin
              div_req <= '{start: 1'b1, neg: tg_new[47],
                           num: DIV_NW'({tg_mag, FRAC'(0)}), den: DIV_DW'(emis)};
              state <= PX_DV1W;
            end
          end
        end

        PX_DV1W: begin
          if (div_done) begin
            vc <= sat48(div_q);
            mul_req <= '{start: 1'b1, neg: ksta[47] ^ dt[47],
                         a: mag64(64'(ksta)), b: mag64(64'(dt))};
            state <= PX_M3W;
          end
        end

        PX_M3W: begin
          if (mul_done) begin
            a1 <= a1_new;
            mul_req <= '{start: 1'b1, neg: tgc[47] ^ acp[47],
                         a: mag64(64'(tgc)), b: mag64(64'(acp))};
            state <= PX_M4W;
          end
        end

        PX_M4W: begin
          if (mul_done) begin
            mul_req <= '{start: 1'b1, neg: a1[47] ^ a2_new[47],
                         a: mag64(64'(a1)), b: mag64(64'(a2_new))};
            state <= PX_M5W;
          end
        end

        PX_M5W: begin
          if (mul_done) begin
            if (mq == '0) begin
              res_temp <= '0;
              res_kind <= 1'b1;
              res_pix <= idx_r[5:0];
              res_err <= 1'b1;
              state <= EMIT;
            end else begin
              div_req <= '{start: 1'b1, neg: vc[47] ^ mq[47],
                           num: DIV_NW'({mag64(64'(vc)), 8'b0}),
                           den: DIV_DW'(mag64(64'(mq)))};
              state <= PX_DV2W;
            end
          end
        end

        PX_DV2W: begin
          if (div_done) begin
            if (x[127]) begin
              res_temp <= '0;
              res_kind <= 1'b1;
              res_pix <= idx_r[5:0];
              res_err <= 1'b1;
              state <= EMIT;
            end else begin
              sq_req <= '{start: 1'b1, arg: SQ_IW'(x <<< 24)};
              state <= PX_SQ1W;
            end
          end
        end

        PX_SQ1W: begin
          if (sq_done) begin
            sq_req <= '{start: 1'b1, arg: SQ_IW'(sq_root)};
            state <= PX_SQ2W;
          end
        end

        PX_SQ2W: begin
          if (sq_done) begin
            res_temp <= temp_obj;
            res_kind <= 1'b1;
            res_pix <= idx_r[5:0];
            res_err <= 1'b0;
            state <= EMIT;
          end
        end

        EMIT: begin
          if (!out_valid || !out_stall) begin
            temperature <= res_temp;
            result_kind <= res_kind;
            result_pixel <= res_pix;
            range_error <= res_err;
            out_valid <= 1'b1;
            state <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

  // Only one shared unit is started at a time.
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_req.start, div_req.start, sq_req.start}))
    else $error("more than one arithmetic unit started in one cycle");

  // A multiplier result only arrives while the sequencer waits for one.
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == PT_M1W) || (state == PT_M2W) || (state == K4_M1W) ||
                 (state == K4_M2W) || (state == PX_M1W) || (state == PX_M2W) ||
                 (state == PX_M3W) || (state == PX_M4W) || (state == PX_M5W))
    else $error("multiplier finished outside a wait state");

  // No item is taken before the reset-time fourth power is ready.
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    k4_init |-> in_stall)
    else $error("item accepted during initialization");

  // A flagged result carries temperature zero.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (temperature == '0))
    else $error("range error with nonzero temperature");

  // Ambient results always report pixel zero.
  a_amb_pix: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_kind) |-> (result_pixel == '0))
    else $error("ambient result with nonzero pixel number");

endmodule

/* tb/thermopile_pixel_temperature_tb.sv */
// Self-checking testbench for the thermopile pixel temperature block.
module thermopile_pixel_temperature_tb;
  import tpt_pkg::*;

  typedef logic signed [127:0] big_t;

  // Item codes on the func field.
  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_PTAT = 2'd1;
  localparam logic [1:0] FN_COMP = 2'd2;
  localparam logic [1:0] FN_PIXEL = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_VTH = 3'd0;
  localparam logic [2:0] REG_K1 = 3'd1;
  localparam logic [2:0] REG_K2 = 3'd2;
  localparam logic [2:0] REG_TGC = 3'd3;
  localparam logic [2:0] REG_EMIS = 3'd4;
  localparam logic [2:0] REG_KSTA = 3'd5;
  localparam logic [2:0] REG_ACP = 3'd6;
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam int NPIX = 64;
  localparam int FB = 24;
  localparam big_t UNIT = big_t'(1) <<< FB;
  localparam big_t AMB_REF = big_t'(25) <<< FB;
  localparam big_t KOFS_Q = (big_t'(27315) * UNIT + 50) / 100;
  localparam big_t KOFS_Q8 = (big_t'(27315) * 256 + 50) / 100;
  localparam logic [55:0] K4_TOP = '1;
  localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48 = 48'h8000_0000_0000;
  localparam int DRAIN = 400;
  localparam longint LIMIT = 4000000;

  typedef struct packed {
    logic signed [19:0] temp;
    logic               kind;
    logic [5:0]         pix;
    logic               err;
  } reading_t;

  typedef struct {
    logic [1:0]  fn;
    logic [6:0]  idx;
    int          raw;
    logic [47:0] off;
    logic [47:0] slope;
    logic [47:0] sens;
    bit          typed;
    reading_t    want;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] func;
  logic [6:0] pixel_index;
  logic signed [16:0] raw_sample;
  logic signed [47:0] coef_offset, coef_slope, coef_sensitivity;
  logic out_valid, out_stall;
  logic signed [19:0] temperature;
  logic result_kind;
  logic [5:0] result_pixel;
  logic range_error;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;

  thermopile_pixel_temperature u_dut (
    .clk, .rst, .in_valid, .in_stall, .func, .pixel_index, .raw_sample,
    .coef_offset, .coef_slope, .coef_sensitivity, .out_valid, .out_stall,
    .temperature, .result_kind, .result_pixel, .range_error,
    .cfg_write, .cfg_index, .cfg_data
  );

  // Shadow copy of the block's registers and stores.
  logic signed [47:0] vth, k1, k2, tgc, ksta, acp;
  logic [25:0] emis;
  logic signed [47:0] off_mem [0:NPIX];
  logic signed [47:0] slope_mem [0:NPIX];
  logic signed [47:0] sens_mem [0:NPIX-1];
  bit loaded [0:NPIX];
  logic signed [47:0] amb;
  logic [55:0] amb_k4;
  logic signed [47:0] cp_val;

  reading_t pending_temps[$];
  int errors = 0;
  int send_pct = 0;
  int recv_pct = 0;
  longint cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // A stuck handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("thermopile_pixel_temperature regression: fail");
      $finish;
    end
  end

  function automatic big_t clamp(big_t v, int w);
    big_t hi, lo;
    hi = (big_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q.F product, floored and clamped to 48 bits.
  function automatic big_t qmul(big_t a, big_t b);
    return clamp((a * b) >>> FB, 48);
  endfunction

  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0] r, c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= n) r = c;
    end
    return r;
  endfunction

  // Kelvin fourth power of the stored ambient, Q8, clamped to 56 bits.
  function automatic logic [55:0] kelvin_fourth(logic signed [47:0] ta);
    big_t k;
    logic [127:0] m, s, r;
    k = big_t'(ta) + KOFS_Q;
    m = k < 0 ? -k : k;
    s = (m * m) >> FB;
    if (s[127:64] != 0) return K4_TOP;
    r = (s * s) >> (2 * FB - 8);
    return r > K4_TOP ? K4_TOP : r[55:0];
  endfunction

  task automatic reset_shadow();
    vth = '0; k1 = '0; k2 = '0; tgc = '0; ksta = '0; acp = '0;
    emis = 26'd1 << 24;
    for (int i = 0; i <= NPIX; i++) loaded[i] = 0;
    amb = AMB_REF[47:0];
    amb_k4 = kelvin_fourth(amb);
    cp_val = '0;
  endtask

  task automatic shadow_config(logic [2:0] ix, logic [47:0] v);
    case (ix)
      REG_VTH: vth = v;
      REG_K1: k1 = v;
      REG_K2: k2 = v;
      REG_TGC: tgc = v;
      REG_EMIS: emis = v[25:0];
      REG_KSTA: ksta = v;
      REG_ACP: acp = v;
      default: ;
    endcase
  endtask

  // Works out what one accepted item does; has is set when a reading follows.
  task automatic predict_temp(input row_t it, output bit has, output reading_t rd);
    big_t raw_q, dt, d, disc, num, q, off, tg, vc, a1, a2, ac, x;
    logic [63:0] t;
    has = 0;
    rd = '0;
    raw_q = big_t'(it.raw) <<< FB;
    dt = clamp(big_t'(amb) - AMB_REF, 48);
    case (it.fn)
      FN_LOAD: begin
        if (it.idx <= NPIX) begin
          off_mem[it.idx] = it.off;
          slope_mem[it.idx] = it.slope;
          if (it.idx < NPIX) sens_mem[it.idx] = it.sens;
          loaded[it.idx] = 1;
        end
      end
      FN_PTAT: begin
        has = 1;
        rd.err = 1;
        d = big_t'(vth) - raw_q;
        disc = big_t'(k1) * big_t'(k1) - ((big_t'(k2) * d) <<< 2);
        if (k2 != 0 && disc >= 0) begin
          num = $signed({64'd0, root_floor(disc)}) - big_t'(k1);
          q = (num <<< FB) / (big_t'(k2) * 2);
          amb = 48'(clamp(q + AMB_REF, 48));
          amb_k4 = kelvin_fourth(amb);
          rd.temp = 20'(clamp(big_t'(amb) >>> (FB - 8), 20));
          rd.err = 0;
        end
      end
      FN_COMP: begin
        cp_val = 48'(clamp(raw_q - (big_t'(off_mem[NPIX]) + qmul(slope_mem[NPIX], dt)), 48));
      end
      default: begin
        if (it.idx < NPIX) begin
          has = 1;
          rd.kind = 1;
          rd.pix = it.idx[5:0];
          rd.err = 1;
          off = clamp(raw_q - (big_t'(off_mem[it.idx]) + qmul(slope_mem[it.idx], dt)), 48);
          tg = clamp(off - qmul(tgc, cp_val), 48);
          if (emis != 0) begin
            vc = clamp((tg <<< 24) / $signed({102'd0, emis}), 48);
            a1 = clamp(UNIT + qmul(ksta, dt), 48);
            a2 = clamp(big_t'(sens_mem[it.idx]) - qmul(tgc, acp), 48);
            ac = qmul(a1, a2);
            if (ac != 0) begin
              x = (vc <<< 8) / ac + $signed({72'd0, amb_k4});
              if (x >= 0) begin
                t = root_floor({64'd0, root_floor(x << 24)});
                rd.temp = 20'(clamp($signed({64'd0, t}) - KOFS_Q8, 20));
                rd.err = 0;
              end
            end
          end
        end
      end
    endcase
  endtask

  // Offers one item and waits for the block to take it.
  task automatic send_item(input row_t it);
    bit has;
    reading_t rd;
    @(negedge clk);
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    func = it.fn;
    pixel_index = it.idx;
    raw_sample = it.raw[16:0];
    coef_offset = it.off;
    coef_slope = it.slope;
    coef_sensitivity = it.sens;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_temp(it, has, rd);
    if (has) pending_temps.push_back(it.typed ? it.want : rd);
  endtask

  task automatic write_reg(logic [2:0] ix, logic [47:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = ix;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    shadow_config(ix, v);
  endtask

  // Mix of full-range, small, extreme and near-unity 48-bit values.
  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return 48'(int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000);
      2: return $urandom_range(0, 1) ? MAX48 : MIN48;
      default: return 48'(UNIT) + 48'($urandom_range(0, 32'h00FF_FFFF));
    endcase
  endfunction

  // Each setting holds the registers for one phase of random items.
  task automatic apply_setting(int p);
    case (p)
      0: begin
        write_reg(REG_VTH, 48'(big_t'(8000) <<< FB));
        write_reg(REG_K1, 48'(big_t'(10) <<< FB));
        write_reg(REG_K2, -48'sd1048576);
        write_reg(REG_TGC, 48'd1 << 20);
        write_reg(REG_EMIS, 48'd15938355);
        write_reg(REG_KSTA, 48'd1 << 16);
        write_reg(REG_ACP, 48'd1 << 20);
        write_reg(REG_NONE, 48'({$urandom, $urandom}));
      end
      1: begin
        write_reg(REG_VTH, MAX48);
        write_reg(REG_K1, MAX48);
        write_reg(REG_K2, MAX48);
        write_reg(REG_TGC, MAX48);
        write_reg(REG_EMIS, 48'd1 << 25);
        write_reg(REG_KSTA, MAX48);
        write_reg(REG_ACP, MAX48);
      end
      2: begin
        write_reg(REG_VTH, MIN48);
        write_reg(REG_K1, MIN48);
        write_reg(REG_K2, MIN48);
        write_reg(REG_TGC, MIN48);
        write_reg(REG_EMIS, '0);
        write_reg(REG_KSTA, MIN48);
        write_reg(REG_ACP, '0);
      end
      default: begin
        write_reg(REG_VTH, 48'(big_t'($urandom_range(6000, 10000)) <<< FB));
        write_reg(REG_K1, 48'($urandom_range(1, 32'h7FFF_FFFF)));
        write_reg(REG_K2, 48'(int'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000));
        write_reg(REG_TGC, pick48());
        write_reg(REG_EMIS, 48'($urandom_range(0, 32'h200_0000)));
        write_reg(REG_KSTA, pick48());
        write_reg(REG_ACP, pick48());
      end
    endcase
  endtask

  // Lets the block finish every item in flight before registers change.
  task automatic settle();
    while (pending_temps.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic row_t random_row();
    row_t it;
    int sel;
    it = '{default: '0};
    sel = $urandom_range(0, 99);
    it.raw = int'($urandom_range(0, 98303)) - 32768;
    it.off = pick48();
    it.slope = pick48();
    it.sens = pick48();
    if (sel < 12) begin
      it.fn = FN_LOAD;
      it.idx = $urandom_range(0, 9) == 0 ? 7'($urandom_range(65, 127))
                                         : 7'($urandom_range(0, NPIX));
    end else if (sel < 24) begin
      it.fn = FN_PTAT;
      it.idx = 7'($urandom);
      if ($urandom_range(0, 1)) it.raw = $urandom_range(6000, 10000);
    end else if (sel < 34) begin
      it.fn = FN_COMP;
      it.idx = 7'($urandom);
    end else begin
      it.fn = FN_PIXEL;
      it.idx = $urandom_range(0, 19) == 0 ? 7'($urandom_range(NPIX, 127))
                                          : 7'($urandom_range(0, NPIX - 1));
      // A pixel with no coefficients yet gets them loaded instead.
      if (it.idx < NPIX && !loaded[it.idx]) it.fn = FN_LOAD;
    end
    return it;
  endfunction

  // Directed rows. The expected reading is typed in only for the error
  // cases that follow from the reset registers: a ptat item with k2 at zero
  // and a pixel whose compensated sensitivity is zero.
  localparam reading_t AMB_FAULT = '{temp: '0, kind: 1'b0, pix: '0, err: 1'b1};
  localparam reading_t PIX5_FAULT = '{temp: '0, kind: 1'b1, pix: 6'd5, err: 1'b1};
  row_t plan [] = '{
    '{FN_LOAD, 7'd64, 0, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_LOAD, 7'd0, 0, MAX48, MIN48, 48'd1 << 24, 0, '0},
    '{FN_LOAD, 7'd63, 0, MIN48, MAX48, MAX48, 0, '0},
    '{FN_LOAD, 7'd5, 0, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_LOAD, 7'd10, 0, 48'd0, 48'd0, 48'd1 << 24, 0, '0},
    '{FN_PTAT, 7'd0, 0, 48'd0, 48'd0, 48'd0, 1, AMB_FAULT},
    '{FN_PTAT, 7'd127, 65535, 48'd0, 48'd0, 48'd0, 1, AMB_FAULT},
    '{FN_PTAT, 7'd64, -32768, 48'd0, 48'd0, 48'd0, 1, AMB_FAULT},
    '{FN_COMP, 7'd0, 0, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_COMP, 7'd127, 65535, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_PIXEL, 7'd5, 1000, 48'd0, 48'd0, 48'd0, 1, PIX5_FAULT},
    '{FN_PIXEL, 7'd10, 0, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_PIXEL, 7'd0, 65535, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_PIXEL, 7'd63, -32768, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_PIXEL, 7'd64, 77, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_PIXEL, 7'd127, -1, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_LOAD, 7'd100, 0, MAX48, MAX48, MAX48, 0, '0},
    '{FN_LOAD, 7'd127, 0, MIN48, MIN48, MIN48, 0, '0},
    '{FN_PIXEL, 7'd10, -1, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_COMP, 7'd64, -32768, 48'd0, 48'd0, 48'd0, 0, '0},
    '{FN_PIXEL, 7'd0, 12345, 48'd0, 48'd0, 48'd0, 0, '0}
  };

  // Receiver side: random stall at the falling edge, check at the rising edge.
  initial out_stall = 1'b0;
  always @(negedge clk) out_stall = recv_pct > 0 && $urandom_range(0, 99) < recv_pct;

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_temps.size() == 0) begin
        $display("%0t: unexpected reading temp %0d kind %0d pixel %0d err %0d", $time,
                 temperature, result_kind, result_pixel, range_error);
        errors++;
      end else begin
        want = pending_temps.pop_front();
        if (temperature !== want.temp) begin
          $display("%0t: temperature expected %0d actual %0d", $time, want.temp, temperature);
          errors++;
        end
        if (result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, result_kind);
          errors++;
        end
        if (result_pixel !== want.pix) begin
          $display("%0t: result_pixel expected %0d actual %0d", $time, want.pix, result_pixel);
          errors++;
        end
        if (range_error !== want.err) begin
          $display("%0t: range_error expected %0d actual %0d", $time, want.err, range_error);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows on reset registers, then six phases
  // of random items, each under a register setting and one of four idle patterns.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_LOAD;
    pixel_index = '0;
    raw_sample = '0;
    coef_offset = '0;
    coef_slope = '0;
    coef_sensitivity = '0;
    cfg_write = 1'b0;
    cfg_index = REG_VTH;
    cfg_data = '0;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) send_item(plan[i]);

    for (int p = 0; p < 6; p++) begin
      @(negedge clk);
      in_valid = 1'b0;
      settle();
      apply_setting(p);
      case (p % 4)
        0: begin send_pct = 0; recv_pct = 0; end
        1: begin send_pct = 67; recv_pct = 0; end
        2: begin send_pct = 0; recv_pct = 67; end
        default: begin send_pct = 26; recv_pct = 26; end
      endcase
      for (int n = 0; n < 200; n++) send_item(random_row());
    end

    @(negedge clk);
    in_valid = 1'b0;
    settle();
    if (errors == 0) $display("thermopile_pixel_temperature regression: pass");
    else $display("thermopile_pixel_temperature regression: fail");
    $finish;
  end

endmodule

/* sim.f */
hdl/tpt_pkg.sv
hdl/tpt_mul.sv
hdl/tpt_div.sv
hdl/tpt_sqrt.sv
hdl/thermopile_pixel_temperature.sv
tb/thermopile_pixel_temperature_tb.sv
